[sv/sidac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidac_pkg
// Shared types, constants and helper functions for the signed integer to
// decimal ASCII converter.
// ----------------------------------------------------------------------------
package sidac_pkg;

  // Width of the incoming two's complement value.
  localparam int VALUE_W    = 32;
  // Decimal digits needed for the largest magnitude (2147483648).
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  // ASCII codes used on the character port.
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // One double-dabble correction: every BCD digit of 5 or more gets 3 added,
  // so that the following left shift carries into the next digit correctly.
  function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    logic [3:0]       dig;
    res = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dig = bcd[4*i +: 4];
      if (dig >= 4'd5) begin
        res[4*i +: 4] = dig + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

[sv/signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer into its decimal ASCII text, most
// significant character first, with a leading '-' for negative values.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                         Handshake
//  --------  ----------------------------  ------------------------------------
//  request   value[31:0]                   taken when start && !busy
//  result    character[7:0], last          one cycle each, marked by valid
//
//  A request keeps busy high through bit-serial double dabble (one magnitude
//  bit per cycle into a 10-digit BCD shift register), a sign step for a
//  negative value, then a walk over the BCD digits one per cycle, dropping
//  leading zeros and sending the rest.
//  Results leave through an output register in the cycle after they are formed,
//  so a new request may be taken while the final character is still shown.
//  Reset (synchronous, active high) returns the sequencer to idle and drops
//  valid. The receiver cannot stall the result stream.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
  import sidac_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [VALUE_W-1:0]  value,
  output logic                busy,
  output logic                valid,
  output logic [7:0]          character,
  output logic                last
);

  state_t               state, state_next;
  logic [VALUE_W-1:0]   mag;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [DIG_CNT_W-1:0] dig_cnt;
  logic                 negative;

  logic                 valid_next;
  logic [7:0]           character_next;
  logic                 last_next;

  logic [3:0]           top_digit;
  logic                 top_zero;
  logic                 final_digit;
  logic                 accept;

  assign accept      = start && !busy;
  assign top_digit   = bcd[BCD_W-1 -: 4];
  assign top_zero    = (top_digit == 4'd0);
  assign final_digit = (dig_cnt == DIG_CNT_W'(1));

  // BCD digits after the add-3 correction, ready for the next shift.
  assign bcd_adj = dabble_adjust(bcd);

  // Busy whenever a request is being worked on.
  assign busy = (state != ST_IDLE);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (bit_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
          state_next = negative ? ST_SIGN : ST_SCAN;
        end
      end
      ST_SIGN: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!top_zero || final_digit) begin
          state_next = final_digit ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (final_digit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result logic: what goes into the output register this cycle.
  always_comb begin
    valid_next     = 1'b0;
    character_next = CHAR_ZERO + {4'd0, top_digit};
    last_next      = 1'b0;
    case (state)
      ST_SIGN: begin
        valid_next     = 1'b1;
        character_next = CHAR_MINUS;
      end
      ST_SCAN: begin
        valid_next = !top_zero || final_digit;
        last_next  = final_digit;
      end
      ST_EMIT: begin
        valid_next = 1'b1;
        last_next  = final_digit;
      end
      default: begin
        valid_next = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    character <= character_next;
    last      <= last_next;
  end

  // Datapath: magnitude and BCD shift registers with their counters.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          negative <= value[VALUE_W-1];
          mag      <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
          bcd      <= '0;
          bit_cnt  <= '0;
          dig_cnt  <= DIG_CNT_W'(NUM_DIGITS);
        end
      end
      ST_CONVERT: begin
        bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
        mag     <= {mag[VALUE_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      end
      ST_SCAN, ST_EMIT: begin
        bcd     <= {bcd[BCD_W-5:0], 4'd0};
        dig_cnt <= dig_cnt - DIG_CNT_W'(1);
      end
      default: begin
        bcd <= bcd;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Every character sent is a minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (character == CHAR_MINUS) ||
              ((character >= CHAR_ZERO) && (character <= CHAR_NINE)))
    else $error("character outside '-' and '0'..'9'");

  // The sign is never the final character.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    valid && (character == CHAR_MINUS) |-> !last)
    else $error("minus sign flagged as last");

  // A taken request makes the block busy and shows no result the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !valid)
    else $error("request taken without entering conversion");

  // All ten digit slots are still pending while the conversion runs.
  a_digits_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONVERT) |-> (dig_cnt == DIG_CNT_W'(NUM_DIGITS)))
    else $error("digit count disturbed during conversion");
`endif

endmodule

[sim/tb_signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// Self-checking bench for the signed integer to decimal ASCII converter.
// Each accepted request is turned into its expected character stream by a
// predictor in the scoreboard. Every strobed character is then compared
// against the oldest pending character. The stimulus starts with the edge
// values, then runs random values of every length under three sender idling
// patterns.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;
  import sidac_pkg::*;

  // Cycles with neither a request nor a character taken before giving up.
  localparam int STALL_LIMIT = 2000;

  // One expected character of a converted value.
  typedef struct {
    logic [7:0] code;
    logic       is_last;
  } text_char_t;

  // Predicts the decimal text of each request and checks the characters.
  class ascii_scoreboard;
    text_char_t pending_text[$];
    int         errors = 0;

    // Expands one accepted request into its expected characters.
    function void note_request(logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [7:0]         digs[$];
      text_char_t         tc;
      // The most negative value wraps to 2^31, which is its true magnitude.
      mag = v[VALUE_W-1] ? (32'd0 - v) : v;
      do begin
        digs.push_front(CHAR_ZERO + 8'(mag % 32'd10));
        mag = mag / 32'd10;
      end while (mag != 0);
      if (v[VALUE_W-1]) begin
        tc.code    = CHAR_MINUS;
        tc.is_last = 1'b0;
        pending_text.push_back(tc);
      end
      foreach (digs[i]) begin
        tc.code    = digs[i];
        tc.is_last = (i == digs.size() - 1);
        pending_text.push_back(tc);
      end
    endfunction

    // Compares one received character against the oldest expectation.
    function void check_char(logic [7:0] c, logic l);
      text_char_t tc;
      if (pending_text.size() == 0) begin
        $error("unexpected character: character=%0d last=%0b", c, l);
        errors++;
        return;
      end
      tc = pending_text.pop_front();
      if (c !== tc.code) begin
        $error("character mismatch: expected %0d, got %0d", tc.code, c);
        errors++;
      end
      if (l !== tc.is_last) begin
        $error("last mismatch: expected %0b, got %0b", tc.is_last, l);
        errors++;
      end
    endfunction

    function int pending();
      return pending_text.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic [VALUE_W-1:0] value;
  logic               busy;
  logic               valid;
  logic [7:0]         character;
  logic               last;

  ascii_scoreboard sb;
  int              stall_cycles;

  signed_int_to_decimal_ascii uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .busy      (busy),
    .valid     (valid),
    .character (character),
    .last      (last)
  );

  // Free-running 50 MHz clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Monitor: checks characters and records requests at every edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (valid) begin
        sb.check_char(character, last);
      end
      if (start && !busy) begin
        sb.note_request(value);
      end
    end
  end

  // Watchdog on cycles where nothing moves on either channel.
  always @(posedge clk) begin
    if (rst || valid || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Holds start low for one cycle with noise on the value bus.
  task automatic idle_cycle();
    start <= 1'b0;
    value <= $urandom;
    @(posedge clk);
  endtask

  // Sends one request, idling beforehand at the given percentage.
  task automatic send_request(input logic [VALUE_W-1:0] v, input int idle_pct);
    if (idle_pct > 0 && $urandom_range(11) == 0) begin
      repeat ($urandom_range(1, 45)) idle_cycle();
    end
    while ($urandom_range(99) < idle_pct) idle_cycle();
    start <= 1'b1;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stops sending until every expected character has been seen.
  task automatic drain_text();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random value: mostly a random digit count and sign, some raw patterns.
  function automatic logic [VALUE_W-1:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    int     n;
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        // Values near zero and near both ends of the range.
        case ($urandom_range(3))
          0: return 32'($signed($urandom_range(0, 20)) - 10);
          1: return 32'h7FFF_FFFF - $urandom_range(0, 5);
          default: return 32'h8000_0000 + $urandom_range(0, 5);
        endcase
      end
      default: begin
        n  = $urandom_range(1, 10);
        lo = (n == 1) ? 0 : 64'd10 ** (n - 1);
        hi = (64'd10 ** n) - 1;
        if (hi > 64'd2147483648) hi = 64'd2147483648;
        mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
        if ($urandom_range(1) == 1) return 32'(-mag);
        if (mag > 64'd2147483647) mag = 64'd2147483647;
        return 32'(mag);
      end
    endcase
  endfunction

  // Stimulus sequence.
  initial begin
    logic [VALUE_W-1:0] edge_values[$];
    int                 idle_pct[3];

    sb           = new();
    rst          = 1'b1;
    start        = 1'b0;
    value        = '0;
    stall_cycles = 0;
    idle_pct     = '{18, 58, 0};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero, digit count boundaries, both extremes and the most negative value.
    edge_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd9, -32'sd10,
                    32'd99, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                    32'h7FFF_FFFE, 32'd1000000000, 32'd999999999, -32'sd1000000000,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'd123456789, -32'sd987654321,
                    32'd1000};
    foreach (edge_values[i]) begin
      send_request(edge_values[i], 0);
    end
    drain_text();

    // Random values under each idling pattern, draining between phases.
    for (int ph = 0; ph < 3; ph++) begin
      for (int i = 0; i < 147; i++) begin
        send_request(random_value(), idle_pct[ph]);
      end
      drain_text();
    end

    // Allow any stray characters to show up before the verdict.
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
